// ----- hdl/sm4_pkg.sv -----
// SM4 core package: opcode, sequencer state and memory strobe types, S-box table and
// the byte substitution helper.
// No dependencies; used by every module of the SM4 core.
package sm4_pkg;

	// item opcodes; code 3 carries no meaning and is dropped
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENC  = 2'd1,
		OP_DEC  = 2'd2
	} opcode_t;

	// round sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// memory read/write strobes from the sequencer
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	localparam int WORD_W = 32;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// byte-wise S-box over one word (tau)
	function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] v);
		sbox_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

endpackage

// ----- hdl/sm4_if.sv -----
// Valid/ready channel interfaces of the SM4 core: request and response beats.
// No dependencies.
interface sm4_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [4:0]  key_slot;
	logic [31:0] key_word;
	logic [63:0] block_hi;
	logic [63:0] block_lo;

	modport source (output valid, opcode, key_slot, key_word, block_hi, block_lo,
		input ready);
	modport sink (input valid, opcode, key_slot, key_word, block_hi, block_lo,
		output ready);
endinterface

interface sm4_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_hi;
	logic [63:0] result_lo;

	modport source (output valid, result_hi, result_lo, input ready);
	modport sink (input valid, result_hi, result_lo, output ready);
endinterface

// ----- hdl/sm4_key_mem.sv -----
// Round key store: single-port-write, single-port-read synchronous memory,
// registered read data. Depends on sm4_pkg for the strobe struct.
module sm4_key_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                    clk,
	input  sm4_pkg::mem_ctl_t       ctl,
	input  logic [AW-1:0]           wr_addr,
	input  logic [31:0]             wr_data,
	input  logic [AW-1:0]           rd_addr,
	output logic [31:0]             rd_data
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	// write port; contents undefined until written
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/sm4_round.sv -----
// One SM4 round: T = x0 ^ L(tau(x1^x2^x3^rk)).
// Depends on sm4_pkg for the S-box.
module sm4_round (
	input  logic [31:0] x0,
	input  logic [31:0] x1,
	input  logic [31:0] x2,
	input  logic [31:0] x3,
	input  logic [31:0] rk,
	output logic [31:0] t
);

	logic [31:0] mix;
	logic [31:0] sub;

	// key mix and substitution
	assign mix = x1 ^ x2 ^ x3 ^ rk;
	assign sub = sm4_pkg::sbox_word(mix);

	// linear layer, rotations 2/10/18/24
	assign t = x0 ^ sub
		^ {sub[29:0], sub[31:30]}
		^ {sub[21:0], sub[31:22]}
		^ {sub[13:0], sub[31:14]}
		^ {sub[7:0],  sub[31:8]};

endmodule

// ----- hdl/sm4_block_cipher_core_unit.sv -----
// SM4 block cipher core, top level. Depends on sm4_pkg, sm4_if, sm4_key_mem, sm4_round.
// Key load beat: taken while idle, no response. Block beat: 32 rounds at one per cycle, then
// the block moves to the response register once that register is free, and the sequencer
// returns to idle. Requests only between blocks.
// Reset clears the sequencer and response valid; the key store is not cleared and must
// be loaded before use.
module sm4_block_cipher_core_unit #(
	parameter int ROUND_COUNT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sm4_req_if.sink       req,
	sm4_rsp_if.source     rsp
);

	localparam int RW = $clog2(ROUND_COUNT);
	localparam logic [RW-1:0] LAST_RND = RW'(ROUND_COUNT - 1);

	sm4_pkg::state_t   state_q, state_nxt;
	sm4_pkg::opcode_t  op;
	sm4_pkg::mem_ctl_t mem_ctl;

	logic [RW-1:0] rnd_q;
	logic          dec_q;
	logic [31:0]   w_q [4];
	logic [31:0]   rk;
	logic [31:0]   t;
	logic [RW-1:0] rd_addr;
	logic          acc;
	logic          blk_acc;
	logic          last;
	logic          out_free;
	logic          load_out;
	logic          out_valid_q;
	logic [63:0]   res_hi_q;
	logic [63:0]   res_lo_q;

	assign op       = sm4_pkg::opcode_t'(req.opcode);
	assign acc      = req.valid && req.ready;
	assign blk_acc  = acc && (op == sm4_pkg::OP_ENC || op == sm4_pkg::OP_DEC);
	assign last     = (rnd_q == LAST_RND);
	assign out_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sm4_pkg::ST_IDLE: begin
				if (blk_acc) begin
					state_nxt = sm4_pkg::ST_RUN;
				end
			end
			sm4_pkg::ST_RUN: begin
				if (last) begin
					state_nxt = sm4_pkg::ST_DONE;
				end
			end
			sm4_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = sm4_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sm4_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: ready, memory strobes, key address, response load
	always_comb begin
		req.ready  = 1'b0;
		mem_ctl.we = 1'b0;
		mem_ctl.re = 1'b0;
		rd_addr    = '0;
		load_out   = 1'b0;
		case (state_q)
			sm4_pkg::ST_IDLE: begin
				req.ready  = 1'b1;
				mem_ctl.we = acc && op == sm4_pkg::OP_LOAD
					&& 32'(req.key_slot) < ROUND_COUNT;
				mem_ctl.re = blk_acc;
				// first key: slot 0 forwards, last slot backwards
				rd_addr    = (op == sm4_pkg::OP_DEC) ? LAST_RND : '0;
			end
			sm4_pkg::ST_RUN: begin
				mem_ctl.re = !last;
				rd_addr    = dec_q ? (LAST_RND - (rnd_q + 1'b1)) : (rnd_q + 1'b1);
			end
			sm4_pkg::ST_DONE: begin
				load_out = out_free;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm4_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// round counter and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			dec_q <= 1'b0;
		end else if (blk_acc) begin
			rnd_q <= '0;
			dec_q <= (op == sm4_pkg::OP_DEC);
		end else if (state_q == sm4_pkg::ST_RUN) begin
			rnd_q <= rnd_q + 1'b1;
		end
	end

	// key store; loads and block reads never share a cycle
	sm4_key_mem #(
		.DEPTH (ROUND_COUNT),
		.AW    (RW)
	) u_key_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (RW'(req.key_slot)),
		.wr_data (req.key_word),
		.rd_addr (rd_addr),
		.rd_data (rk)
	);

	sm4_round u_round (
		.x0 (w_q[0]),
		.x1 (w_q[1]),
		.x2 (w_q[2]),
		.x3 (w_q[3]),
		.rk (rk),
		.t  (t)
	);

	// word register: load block, then shift in one round result per cycle
	always_ff @(posedge clk) begin
		if (blk_acc) begin
			w_q[0] <= req.block_hi[63:32];
			w_q[1] <= req.block_hi[31:0];
			w_q[2] <= req.block_lo[63:32];
			w_q[3] <= req.block_lo[31:0];
		end else if (state_q == sm4_pkg::ST_RUN) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= w_q[3];
			w_q[3] <= t;
		end
	end

	// response register, words in reversed order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_hi_q <= {w_q[3], w_q[2]};
			res_lo_q <= {w_q[1], w_q[0]};
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.result_hi = res_hi_q;
	assign rsp.result_lo = res_lo_q;

`ifndef SYNTHESIS
	// a response beat only appears from the finishing state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sm4_pkg::ST_DONE))
		else $error("response raised outside finishing state");

	// rounds advance one per cycle without stalls
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sm4_pkg::ST_RUN && !last)
		|=> (state_q == sm4_pkg::ST_RUN && rnd_q == $past(rnd_q) + 1'b1))
		else $error("round counter did not advance");

	// key memory never written and read in the same cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.we && mem_ctl.re))
		else $error("key memory write and read collide");
`endif

endmodule
